// ----- rtl/assert_macros.svh -----
// assertion macros used by the segment test rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SIO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SIO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sio_pkg.sv -----
// shared types, widths and constants of the segment intersect / near test
`timescale 1ns / 1ps
package sio_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = SUM_W - 1;
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int CPP_W   = 2 * HI_W;

  localparam int NEAR_W  = 24;
  localparam int NSQ_W   = 2 * NEAR_W;
  localparam int NLO_W   = NSQ_W / 2;
  localparam int NHI_W   = NSQ_W - NLO_W;
  localparam int NPP_W   = NHI_W + HI_W;

  localparam int TOL_W   = 16;
  localparam int DT_W    = MAG_W + TOL_W;
  localparam int T_W     = SUM_W + TOL_W + 1;

  localparam int SQ_W    = (2 * MAG_W > NSQ_W + MAG_W) ? 2 * MAG_W : NSQ_W + MAG_W;
  localparam int CMP_W   = (MAG_W > NSQ_W) ? MAG_W : NSQ_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // dot and cross quantities of stage three
  localparam int Q_RR  = 0;
  localparam int Q_SS  = 1;
  localparam int Q_RS  = 2;
  localparam int Q_QPR = 3;
  localparam int Q_QPS = 4;
  localparam int Q_DQS = 5;
  localparam int Q_N0  = 6;
  localparam int Q_N1  = 7;
  localparam int Q_DSF = 8;
  localparam int Q_CSF = 9;
  localparam int Q_CRE = 10;
  localparam int Q_QQ  = 11;
  localparam int Q_EE  = 12;
  localparam int Q_FF  = 13;
  localparam int Q_GG  = 14;
  localparam int NQ    = 15;

  // parameter tests: numerator over denominator against [0,1] with tolerance
  localparam int T_P1  = 0;  // -dot(q,s) over |s|^2
  localparam int T_P2  = 1;  // dot(s,f) over |s|^2
  localparam int T_N0  = 2;  // dot(q,r) over |r|^2
  localparam int T_N1  = 3;  // dot(e,r) over |r|^2
  localparam int T_T   = 4;  // cross(q,s) over |cross(r,s)|
  localparam int T_U   = 5;  // cross(q,r) over |cross(r,s)|
  localparam int NT    = 6;

  // denominators
  localparam int D_RR  = 0;
  localparam int D_SS  = 1;
  localparam int D_RS  = 2;
  localparam int ND    = 3;

  localparam int DEN_SEL [NT] = '{D_SS, D_SS, D_RR, D_RR, D_RS, D_RS};

  // endpoint to segment distance checks
  localparam int NP    = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [DT_W-1:0]    dtol_t;
  typedef logic signed [T_W-1:0]     tsc_t;
  typedef logic        [SQ_W-1:0]    sq_t;
  typedef logic        [CPP_W-1:0]   cpp_t;
  typedef logic        [NPP_W-1:0]   npp_t;
  typedef logic        [NEAR_W-1:0]  near_t;
  typedef logic        [NSQ_W-1:0]   nsq_t;
  typedef logic        [TOL_W-1:0]   tol_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_DIST = 1'b0,
    REG_PARAM_TOL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } in_item_t;

  typedef struct packed {
    logic hit_or_near;
    logic crosses;
    logic degenerate;
  } out_item_t;

  // zero tests and endpoint distance results
  typedef struct packed {
    logic rr0;
    logic ss0;
    logic rs0;
    logic qpr0;
    logic qps0;
    logic qq0;
    logic qq_ok;
    logic ee_ok;
    logic ff_ok;
    logic gg_ok;
  } flags_t;

  typedef struct packed {
    logic [2:0] adv;
  } stage_ctl_t;

  typedef struct packed {
    logic [2:0] vld;
  } stage_sts_t;

  function automatic logic q_is_cross(input int k);
    return (k == Q_RS) || (k == Q_QPR) || (k == Q_QPS) || (k == Q_CSF) || (k == Q_CRE);
  endfunction

endpackage

// ----- rtl/sio_if.sv -----
// item channel interfaces: segment pairs in, flags out, register writes
`timescale 1ns / 1ps
interface sio_in_if;
  import sio_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sio_out_if;
  import sio_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sio_cfg_if;
  import sio_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/segment_intersect_or_near.sv -----
// top level: segment pair intersection and closest-approach test pipeline
//
//  channel   dir  payload                                    handshake
//  in_ch     in   two segments, eight signed Q16.8 coords    valid / ready
//  out_ch    out  hit_or_near, crosses, degenerate           valid / ready
//  cfg_ch    in   register index, write data                 valid / ready (always ready)
//
//  seven register stages; one item enters per cycle unless the pipeline is full and stalled
//  the rate is set by the pipeline, every multiplier stage registered
//  synchronous active-low reset clears valid bits and both registers
//  each stage holds while the next one is full and stalled; bubbles close up
`timescale 1ns / 1ps
`include "assert_macros.svh"
module segment_intersect_or_near (
  input  logic  clk,
  input  logic  rst_n,
  sio_in_if.sink    in_ch,
  sio_out_if.source out_ch,
  sio_cfg_if.sink   cfg_ch
);
  import sio_pkg::*;

  near_t      near_dist_r;
  tol_t       tol_r;
  nsq_t       near_sq_r;
  logic [6:0] adv;
  logic [5:0] vld;

  stage_ctl_t prod_ctl, param_ctl;
  stage_sts_t prod_sts, param_sts;
  sum_t       sums [NQ];
  flags_t     flags;
  logic [NT-1:0] below;
  tsc_t       nsh [NT];
  tsc_t       hithr [ND];
  sq_t        csq [NP];
  sq_t        nww [2];

  logic [NT-1:0] above, ins;
  logic [NP-1:0] cp, pn;
  logic          cross_hit;
  out_item_t     out_nxt, out_r;
  logic          out_vld_r;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_dist_r <= '0;
      tol_r       <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_NEAR_DIST: near_dist_r <= cfg_ch.data[NEAR_W-1:0];
        REG_PARAM_TOL: tol_r       <= cfg_ch.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // squared threshold is registered from the register and follows it in the next cycle
  always_ff @(posedge clk) begin
    near_sq_r <= NSQ_W'(near_dist_r) * NSQ_W'(near_dist_r);
  end

  // stage advance: a stage loads when empty or when its successor moves
  assign vld = {param_sts.vld, prod_sts.vld};

  always_comb begin
    adv[6] = !out_vld_r || out_ch.ready;
    for (int k = 5; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ch.ready   = adv[0];
  assign prod_ctl.adv  = adv[2:0];
  assign param_ctl.adv = adv[5:3];

  sio_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .ctl      (prod_ctl),
    .sts      (prod_sts),
    .sums     (sums)
  );

  sio_param u_param (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (prod_sts.vld[2]),
    .sums     (sums),
    .near_sq  (near_sq_r),
    .tol      (tol_r),
    .ctl      (param_ctl),
    .sts      (param_sts),
    .flags    (flags),
    .below    (below),
    .nsh      (nsh),
    .hithr    (hithr),
    .csq      (csq),
    .nww      (nww)
  );

  // stage seven: upper bound compares, square compares and the decision
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      above[t] = nsh[t] > hithr[DEN_SEL[t]];
      ins[t]   = !below[t] && !above[t];
    end
    cp[0] = csq[0] <= nww[D_SS];
    cp[1] = csq[1] <= nww[D_SS];
    cp[2] = csq[2] <= nww[D_RR];
    cp[3] = csq[3] <= nww[D_RR];

    // intersection, with the zero-length and collinear cases
    if (flags.rr0) begin
      cross_hit = flags.ss0 ? flags.qq0 : (flags.qps0 && ins[T_P1]);
    end else if (flags.rs0) begin
      cross_hit = flags.qpr0 && (ins[T_N0] || ins[T_N1] ||
                  (below[T_N0] && above[T_N1]) || (below[T_N1] && above[T_N0]));
    end else begin
      cross_hit = ins[T_T] && ins[T_U];
    end

    // endpoints against the other segment, clamped to its ends
    pn[0] = (flags.ss0 || below[T_P1]) ? flags.qq_ok : above[T_P1] ? flags.ee_ok : cp[0];
    pn[1] = (flags.ss0 || below[T_P2]) ? flags.ff_ok : above[T_P2] ? flags.gg_ok : cp[1];
    pn[2] = (flags.rr0 || below[T_N0]) ? flags.qq_ok : above[T_N0] ? flags.ff_ok : cp[2];
    pn[3] = (flags.rr0 || below[T_N1]) ? flags.ee_ok : above[T_N1] ? flags.gg_ok : cp[3];

    out_nxt.crosses     = cross_hit;
    out_nxt.hit_or_near = cross_hit || (|pn);
    out_nxt.degenerate  = flags.rr0 || flags.ss0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv[6]) begin
      out_vld_r <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) out_r <= out_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  // checks
  `SIO_ASSERT_SAME(a_cross_implies_hit, out_ch.valid && out_ch.data.crosses, out_ch.data.hit_or_near, "crossing item without hit flag")
  `SIO_ASSERT_SAME(a_full_pipe_blocks, out_ch.valid && !out_ch.ready && (&vld), !in_ch.ready, "item accepted into a full stalled pipeline")
  `SIO_ASSERT_NEXT(a_out_from_stage6, !out_vld_r && !vld[5], !out_vld_r, "result without an item in the last stage")

endmodule

// ----- rtl/sio_prod.sv -----
// stages one to three: coordinate differences, products, dot and cross sums
`timescale 1ns / 1ps
module sio_prod (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  sio_pkg::in_item_t  in_item,
  input  sio_pkg::stage_ctl_t ctl,
  output sio_pkg::stage_sts_t sts,
  output sio_pkg::sum_t      sums [sio_pkg::NQ]
);
  import sio_pkg::*;

  localparam int RX = 0;
  localparam int RY = 1;
  localparam int SX = 2;
  localparam int SY = 3;
  localparam int QX = 4;
  localparam int QY = 5;
  localparam int EX = 6;
  localparam int EY = 7;
  localparam int FX = 8;
  localparam int FY = 9;
  localparam int GX = 10;
  localparam int GY = 11;
  localparam int NDF = 12;

  logic [2:0] vld_r;
  diff_t      df_nxt [NDF];
  diff_t      df_r   [NDF];
  diff_t      op_a1  [NQ];
  diff_t      op_b1  [NQ];
  diff_t      op_a2  [NQ];
  diff_t      op_b2  [NQ];
  prod_t      pa_nxt [NQ];
  prod_t      pb_nxt [NQ];
  prod_t      pa_r   [NQ];
  prod_t      pb_r   [NQ];
  sum_t       sum_nxt [NQ];
  sum_t       sum_r   [NQ];

  // stage one: r = B-A, s = D-C, q = C-A, e = D-A, f = B-C, g = B-D
  always_comb begin
    df_nxt[RX] = DIFF_W'(in_item.first_end_x) - DIFF_W'(in_item.first_start_x);
    df_nxt[RY] = DIFF_W'(in_item.first_end_y) - DIFF_W'(in_item.first_start_y);
    df_nxt[SX] = DIFF_W'(in_item.second_end_x) - DIFF_W'(in_item.second_start_x);
    df_nxt[SY] = DIFF_W'(in_item.second_end_y) - DIFF_W'(in_item.second_start_y);
    df_nxt[QX] = DIFF_W'(in_item.second_start_x) - DIFF_W'(in_item.first_start_x);
    df_nxt[QY] = DIFF_W'(in_item.second_start_y) - DIFF_W'(in_item.first_start_y);
    df_nxt[EX] = DIFF_W'(in_item.second_end_x) - DIFF_W'(in_item.first_start_x);
    df_nxt[EY] = DIFF_W'(in_item.second_end_y) - DIFF_W'(in_item.first_start_y);
    df_nxt[FX] = DIFF_W'(in_item.first_end_x) - DIFF_W'(in_item.second_start_x);
    df_nxt[FY] = DIFF_W'(in_item.first_end_y) - DIFF_W'(in_item.second_start_y);
    df_nxt[GX] = DIFF_W'(in_item.first_end_x) - DIFF_W'(in_item.second_end_x);
    df_nxt[GY] = DIFF_W'(in_item.first_end_y) - DIFF_W'(in_item.second_end_y);
  end

  // stage two operands: dot(a,b) = ax*bx + ay*by, cross(a,b) = ax*by - ay*bx
  always_comb begin
    op_a1[Q_RR]  = df_r[RX]; op_b1[Q_RR]  = df_r[RX]; op_a2[Q_RR]  = df_r[RY]; op_b2[Q_RR]  = df_r[RY];
    op_a1[Q_SS]  = df_r[SX]; op_b1[Q_SS]  = df_r[SX]; op_a2[Q_SS]  = df_r[SY]; op_b2[Q_SS]  = df_r[SY];
    op_a1[Q_RS]  = df_r[RX]; op_b1[Q_RS]  = df_r[SY]; op_a2[Q_RS]  = df_r[RY]; op_b2[Q_RS]  = df_r[SX];
    op_a1[Q_QPR] = df_r[QX]; op_b1[Q_QPR] = df_r[RY]; op_a2[Q_QPR] = df_r[QY]; op_b2[Q_QPR] = df_r[RX];
    op_a1[Q_QPS] = df_r[QX]; op_b1[Q_QPS] = df_r[SY]; op_a2[Q_QPS] = df_r[QY]; op_b2[Q_QPS] = df_r[SX];
    op_a1[Q_DQS] = df_r[QX]; op_b1[Q_DQS] = df_r[SX]; op_a2[Q_DQS] = df_r[QY]; op_b2[Q_DQS] = df_r[SY];
    op_a1[Q_N0]  = df_r[QX]; op_b1[Q_N0]  = df_r[RX]; op_a2[Q_N0]  = df_r[QY]; op_b2[Q_N0]  = df_r[RY];
    op_a1[Q_N1]  = df_r[EX]; op_b1[Q_N1]  = df_r[RX]; op_a2[Q_N1]  = df_r[EY]; op_b2[Q_N1]  = df_r[RY];
    op_a1[Q_DSF] = df_r[SX]; op_b1[Q_DSF] = df_r[FX]; op_a2[Q_DSF] = df_r[SY]; op_b2[Q_DSF] = df_r[FY];
    op_a1[Q_CSF] = df_r[SX]; op_b1[Q_CSF] = df_r[FY]; op_a2[Q_CSF] = df_r[SY]; op_b2[Q_CSF] = df_r[FX];
    op_a1[Q_CRE] = df_r[RX]; op_b1[Q_CRE] = df_r[EY]; op_a2[Q_CRE] = df_r[RY]; op_b2[Q_CRE] = df_r[EX];
    op_a1[Q_QQ]  = df_r[QX]; op_b1[Q_QQ]  = df_r[QX]; op_a2[Q_QQ]  = df_r[QY]; op_b2[Q_QQ]  = df_r[QY];
    op_a1[Q_EE]  = df_r[EX]; op_b1[Q_EE]  = df_r[EX]; op_a2[Q_EE]  = df_r[EY]; op_b2[Q_EE]  = df_r[EY];
    op_a1[Q_FF]  = df_r[FX]; op_b1[Q_FF]  = df_r[FX]; op_a2[Q_FF]  = df_r[FY]; op_b2[Q_FF]  = df_r[FY];
    op_a1[Q_GG]  = df_r[GX]; op_b1[Q_GG]  = df_r[GX]; op_a2[Q_GG]  = df_r[GY]; op_b2[Q_GG]  = df_r[GY];
  end

  // stage two products, stage three sums
  always_comb begin
    for (int k = 0; k < NQ; k++) begin
      pa_nxt[k] = PROD_W'(op_a1[k]) * PROD_W'(op_b1[k]);
      pb_nxt[k] = PROD_W'(op_a2[k]) * PROD_W'(op_b2[k]);
      if (q_is_cross(k)) begin
        sum_nxt[k] = SUM_W'(pa_r[k]) - SUM_W'(pb_r[k]);
      end else begin
        sum_nxt[k] = SUM_W'(pa_r[k]) + SUM_W'(pb_r[k]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ctl.adv[0]) vld_r[0] <= in_valid;
      if (ctl.adv[1]) vld_r[1] <= vld_r[0];
      if (ctl.adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.adv[0]) df_r <= df_nxt;
    if (ctl.adv[1]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl.adv[2]) sum_r <= sum_nxt;
  end

  assign sts.vld = vld_r;
  assign sums    = sum_r;

endmodule

// ----- rtl/sio_param.sv -----
// stages four to six: zero tests, tolerance scaling, squared distance products
`timescale 1ns / 1ps
module sio_param (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sio_pkg::sum_t       sums [sio_pkg::NQ],
  input  sio_pkg::nsq_t       near_sq,
  input  sio_pkg::tol_t       tol,
  input  sio_pkg::stage_ctl_t ctl,
  output sio_pkg::stage_sts_t sts,
  output sio_pkg::flags_t     flags,
  output logic [sio_pkg::NT-1:0] below,
  output sio_pkg::tsc_t       nsh [sio_pkg::NT],
  output sio_pkg::tsc_t       hithr [sio_pkg::ND],
  output sio_pkg::sq_t        csq [sio_pkg::NP],
  output sio_pkg::sq_t        nww [2]
);
  import sio_pkg::*;

  function automatic mag_t mag_abs(input sum_t v);
    sum_t n;
    n = -v;
    return v[SUM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  logic [2:0] vld_r;

  // stage four
  flags_t f4_nxt, f4_r;
  sum_t   num4_nxt [NT];
  sum_t   num4_r   [NT];
  mag_t   den4_nxt [ND];
  mag_t   den4_r   [ND];
  mag_t   cm4_nxt  [NP];
  mag_t   cm4_r    [NP];
  logic   rs_neg;
  sum_t   qps_neg, qpr_neg, dqs_neg;

  // stage five
  flags_t f5_r;
  sum_t   num5_r   [NT];
  mag_t   den5_r   [ND];
  dtol_t  dtol_nxt [ND];
  dtol_t  dtol_r   [ND];
  cpp_t   cll_nxt [NP], clh_nxt [NP], chh_nxt [NP];
  cpp_t   cll_r   [NP], clh_r   [NP], chh_r   [NP];
  npp_t   nll_nxt [2], nlh_nxt [2], nhl_nxt [2], nhh_nxt [2];
  npp_t   nll_r   [2], nlh_r   [2], nhl_r   [2], nhh_r   [2];

  // stage six
  flags_t        f6_r;
  logic [NT-1:0] bl_nxt, bl_r;
  tsc_t          nsh_nxt [NT];
  tsc_t          nsh_r   [NT];
  tsc_t          hth_nxt [ND];
  tsc_t          hth_r   [ND];
  sq_t           csq_nxt [NP];
  sq_t           csq_r   [NP];
  sq_t           nww_nxt [2];
  sq_t           nww_r   [2];
  tsc_t          lo_sum  [NT];

  // stage four: zero tests, endpoint distance compares, sign fold of the crossing test, magnitudes
  always_comb begin
    rs_neg  = sums[Q_RS][SUM_W-1];
    qps_neg = -sums[Q_QPS];
    qpr_neg = -sums[Q_QPR];
    dqs_neg = -sums[Q_DQS];

    f4_nxt.rr0   = (sums[Q_RR] == '0);
    f4_nxt.ss0   = (sums[Q_SS] == '0);
    f4_nxt.rs0   = (sums[Q_RS] == '0);
    f4_nxt.qpr0  = (sums[Q_QPR] == '0);
    f4_nxt.qps0  = (sums[Q_QPS] == '0);
    f4_nxt.qq0   = (sums[Q_QQ] == '0);
    f4_nxt.qq_ok = CMP_W'(sums[Q_QQ][MAG_W-1:0]) <= CMP_W'(near_sq);
    f4_nxt.ee_ok = CMP_W'(sums[Q_EE][MAG_W-1:0]) <= CMP_W'(near_sq);
    f4_nxt.ff_ok = CMP_W'(sums[Q_FF][MAG_W-1:0]) <= CMP_W'(near_sq);
    f4_nxt.gg_ok = CMP_W'(sums[Q_GG][MAG_W-1:0]) <= CMP_W'(near_sq);

    num4_nxt[T_P1] = dqs_neg;
    num4_nxt[T_P2] = sums[Q_DSF];
    num4_nxt[T_N0] = sums[Q_N0];
    num4_nxt[T_N1] = sums[Q_N1];
    num4_nxt[T_T]  = rs_neg ? qps_neg : sums[Q_QPS];
    num4_nxt[T_U]  = rs_neg ? qpr_neg : sums[Q_QPR];

    den4_nxt[D_RR] = sums[Q_RR][MAG_W-1:0];
    den4_nxt[D_SS] = sums[Q_SS][MAG_W-1:0];
    den4_nxt[D_RS] = mag_abs(sums[Q_RS]);

    // perpendicular cross products of the four endpoint checks
    cm4_nxt[0] = mag_abs(sums[Q_QPS]);
    cm4_nxt[1] = mag_abs(sums[Q_CSF]);
    cm4_nxt[2] = mag_abs(sums[Q_QPR]);
    cm4_nxt[3] = mag_abs(sums[Q_CRE]);
  end

  // stage five: tolerance products and split squares
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      dtol_nxt[d] = DT_W'(den4_r[d]) * DT_W'(tol);
    end
    for (int i = 0; i < NP; i++) begin
      cll_nxt[i] = CPP_W'(cm4_r[i][LO_W-1:0]) * CPP_W'(cm4_r[i][LO_W-1:0]);
      clh_nxt[i] = CPP_W'(cm4_r[i][LO_W-1:0]) * CPP_W'(cm4_r[i][MAG_W-1:LO_W]);
      chh_nxt[i] = CPP_W'(cm4_r[i][MAG_W-1:LO_W]) * CPP_W'(cm4_r[i][MAG_W-1:LO_W]);
    end
    // near distance squared times |r|^2 (index 0) and |s|^2 (index 1)
    for (int j = 0; j < 2; j++) begin
      nll_nxt[j] = NPP_W'(near_sq[NLO_W-1:0]) * NPP_W'(den4_r[j][LO_W-1:0]);
      nlh_nxt[j] = NPP_W'(near_sq[NLO_W-1:0]) * NPP_W'(den4_r[j][MAG_W-1:LO_W]);
      nhl_nxt[j] = NPP_W'(near_sq[NSQ_W-1:NLO_W]) * NPP_W'(den4_r[j][LO_W-1:0]);
      nhh_nxt[j] = NPP_W'(near_sq[NSQ_W-1:NLO_W]) * NPP_W'(den4_r[j][MAG_W-1:LO_W]);
    end
  end

  // stage six: below flags, upper thresholds, square sums
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      nsh_nxt[t] = tsc_t'(num5_r[t]) <<< TOL_W;
      lo_sum[t]  = nsh_nxt[t] + tsc_t'(dtol_r[DEN_SEL[t]]);
      bl_nxt[t]  = lo_sum[t][T_W-1];
    end
    for (int d = 0; d < ND; d++) begin
      hth_nxt[d] = (tsc_t'(den5_r[d]) <<< TOL_W) + tsc_t'(dtol_r[d]);
    end
    for (int i = 0; i < NP; i++) begin
      csq_nxt[i] = (sq_t'(chh_r[i]) << (2 * LO_W)) + (sq_t'(clh_r[i]) << (LO_W + 1))
                 + sq_t'(cll_r[i]);
    end
    for (int j = 0; j < 2; j++) begin
      nww_nxt[j] = (sq_t'(nhh_r[j]) << (NLO_W + LO_W)) + (sq_t'(nhl_r[j]) << NLO_W)
                 + (sq_t'(nlh_r[j]) << LO_W) + sq_t'(nll_r[j]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ctl.adv[0]) vld_r[0] <= in_valid;
      if (ctl.adv[1]) vld_r[1] <= vld_r[0];
      if (ctl.adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      f4_r   <= f4_nxt;
      num4_r <= num4_nxt;
      den4_r <= den4_nxt;
      cm4_r  <= cm4_nxt;
    end
    if (ctl.adv[1]) begin
      f5_r   <= f4_r;
      num5_r <= num4_r;
      den5_r <= den4_r;
      dtol_r <= dtol_nxt;
      cll_r  <= cll_nxt;
      clh_r  <= clh_nxt;
      chh_r  <= chh_nxt;
      nll_r  <= nll_nxt;
      nlh_r  <= nlh_nxt;
      nhl_r  <= nhl_nxt;
      nhh_r  <= nhh_nxt;
    end
    if (ctl.adv[2]) begin
      f6_r  <= f5_r;
      bl_r  <= bl_nxt;
      nsh_r <= nsh_nxt;
      hth_r <= hth_nxt;
      csq_r <= csq_nxt;
      nww_r <= nww_nxt;
    end
  end

  assign sts.vld = vld_r;
  assign flags   = f6_r;
  assign below   = bl_r;
  assign nsh     = nsh_r;
  assign hithr   = hth_r;
  assign csq     = csq_r;
  assign nww     = nww_r;

endmodule
